@@ design/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants of the random-swap shuffle block
// Record layouts, controller states, draw-unit control and the generator
// constants of the minimal-standard sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rss_pkg;

  // Store geometry.
  localparam int unsigned Capacity  = 64;
  localparam int unsigned AddrW     = $clog2(Capacity);
  localparam int unsigned CountW    = 7;
  localparam int unsigned WordW     = 64;
  localparam int unsigned NumFields = 4;
  localparam int unsigned FieldW    = $clog2(NumFields);

  // Field order inside the stores, which is also the draw order.
  localparam logic [FieldW-1:0] FieldPos  = 2'd0;
  localparam logic [FieldW-1:0] FieldMomX = 2'd1;
  localparam logic [FieldW-1:0] FieldMomY = 2'd2;
  localparam logic [FieldW-1:0] FieldMomZ = 2'd3;

  // Minimal-standard generator.
  localparam int unsigned      SeedW     = 31;
  localparam int unsigned      MultW     = 15;
  localparam logic [SeedW-1:0] SeedReset = 31'd31207321;
  localparam logic [SeedW-1:0] SeedMod   = 31'h7FFF_FFFF;
  localparam logic [MultW-1:0] SeedMult  = 15'd16807;

  localparam logic [CountW-1:0] CountReset = 7'd64;

  // One loaded record.
  typedef struct packed {
    logic [WordW-1:0] position;
    logic [WordW-1:0] mom_x;
    logic [WordW-1:0] mom_y;
    logic [WordW-1:0] mom_z;
  } in_word_t;

  // One emitted record.
  typedef struct packed {
    logic [WordW-1:0] out_position;
    logic [WordW-1:0] out_mom_x;
    logic [WordW-1:0] out_mom_y;
    logic [WordW-1:0] out_mom_z;
    logic             last;
  } out_word_t;

  // Step enables from the controller to the draw unit.
  typedef struct packed {
    logic mul_en;
    logic fold_en;
    logic scale_en;
  } draw_ctrl_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MUL,
    ST_FOLD,
    ST_SCALE,
    ST_DIV,
    ST_WR_I,
    ST_WR_J,
    ST_E_RD,
    ST_E_LD,
    ST_E_OUT
  } state_e;

endpackage

`default_nettype wire

@@ design/rss_ram.sv @@
// ----------------------------------------------------------------------------
// rss_ram: generic single-port-write, single-port-read memory
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/rss_draw.sv @@
// ----------------------------------------------------------------------------
// rss_draw: swap-partner generator
// Holds the persistent seed, advances it by one minimal-standard step and
// scales the new seed to a partner index below the run length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rss_draw (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire rss_pkg::draw_ctrl_t           ctrl_i,
  input  wire logic [rss_pkg::CountW-1:0]    run_len_i,
  output logic      [rss_pkg::AddrW-1:0]     j_o
);

  localparam int unsigned ProdW  = rss_pkg::SeedW + rss_pkg::MultW;
  localparam int unsigned ScaleW = rss_pkg::CountW + rss_pkg::SeedW;

  logic [rss_pkg::SeedW-1:0] seed_q, seed_d;
  logic [ProdW-1:0]          prod_q;
  logic [ScaleW-1:0]         scale_q;
  logic [rss_pkg::SeedW:0]   fold_sum;
  logic [rss_pkg::CountW-1:0] est, est_p1, j_raw, j_max, j_clamp;
  logic [ScaleW-1:0]         thresh;

  // Seed register persists across runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= rss_pkg::SeedReset;
    end else begin
      seed_q <= seed_d;
    end
  end

  // Product and scaled seed registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= seed_q * rss_pkg::SeedMult;
    end
    if (ctrl_i.scale_en) begin
      scale_q <= run_len_i * seed_q;
    end
  end

  // Reduction mod 2^31-1: add the high part onto the low part, then one
  // conditional subtract.
  always_comb begin
    fold_sum = {1'b0, prod_q[rss_pkg::SeedW-1:0]}
             + (rss_pkg::SeedW+1)'(prod_q[ProdW-1:rss_pkg::SeedW]);
    if (fold_sum >= {1'b0, rss_pkg::SeedMod}) begin
      fold_sum = fold_sum - {1'b0, rss_pkg::SeedMod};
    end
    seed_d = ctrl_i.fold_en ? fold_sum[rss_pkg::SeedW-1:0] : seed_q;
  end

  // Division by 2^31-2: the shift estimate is exact or one low, so one
  // compare against (est+1)*(2^31-2) settles it. The top seed value would
  // give the run length itself, so the result is clamped to n-1.
  always_comb begin
    est     = scale_q[ScaleW-1:rss_pkg::SeedW];
    est_p1  = est + 1'b1;
    thresh  = {est_p1, {rss_pkg::SeedW{1'b0}}} - ScaleW'({est_p1, 1'b0});
    j_raw   = (scale_q >= thresh) ? est_p1 : est;
    j_max   = run_len_i - 1'b1;
    j_clamp = (j_raw > j_max) ? j_max : j_raw;
    j_o     = j_clamp[rss_pkg::AddrW-1:0];
  end

  // The seed stays inside 1..2^31-2.
  a_seed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seed_q != '0) && (seed_q != rss_pkg::SeedMod))
    else $error("seed left the generator range");

  // A nonzero seed has no fixed point, so every step changes it.
  a_seed_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.fold_en |=> (seed_q != $past(seed_q)))
    else $error("seed did not advance on a draw");

endmodule

`default_nettype wire

@@ design/random_swap_shuffle_four_fields_top.sv @@
// Sequence: a record is stored in the cycle it is accepted; the shuffle then
// runs each field swap as three draw steps (MUL, FOLD, SCALE), the partner
// read (DIV) and two writes through the one write port (WR_I, WR_J); each
// result is then read (E_RD), loaded (E_LD) and held (E_OUT) until taken.
// No new record is accepted until the whole run has been emitted.
// Reset: seed 31207321, count 64, load index 0; the stores are not cleared.
// ----------------------------------------------------------------------------
// random_swap_shuffle_four_fields_top: four-field random-swap shuffle
// Loads records into four stores, swaps every field of every index with a
// drawn partner, then streams the shuffled records out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module random_swap_shuffle_four_fields_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [rss_pkg::CountW-1:0] cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire rss_pkg::in_word_t          in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rss_pkg::out_word_t              out_data_o
);

  rss_pkg::state_e             state_q, state_d;
  logic [rss_pkg::CountW-1:0]  count_q, load_q, load_d;
  logic [rss_pkg::AddrW-1:0]   i_q, i_d, j_q, j_d, j_draw;
  logic [rss_pkg::FieldW-1:0]  f_q, f_d;
  logic [rss_pkg::WordW-1:0]   a_q, a_d;
  rss_pkg::out_word_t          out_q, out_d;
  rss_pkg::draw_ctrl_t         draw_ctrl;

  logic [rss_pkg::CountW-1:0]  run_len, len_m1, load_at;
  logic                        i_last;

  logic [rss_pkg::NumFields-1:0]                    ram_we, ram_re;
  logic [rss_pkg::AddrW-1:0]                        ram_waddr, ram_raddr;
  logic [rss_pkg::NumFields-1:0][rss_pkg::WordW-1:0] ram_wdata, ram_rdata;

  // Configuration is always writable; the user must change it only while idle, as the block itself does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= rss_pkg::CountReset;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Run length saturated to 1..Capacity.
  always_comb begin
    if (count_q == '0) begin
      run_len = rss_pkg::CountW'(1);
    end else if (count_q > rss_pkg::CountW'(rss_pkg::Capacity)) begin
      run_len = rss_pkg::CountW'(rss_pkg::Capacity);
    end else begin
      run_len = count_q;
    end
    len_m1  = run_len - 1'b1;
    load_at = (load_q > len_m1) ? len_m1 : load_q;
    i_last  = (rss_pkg::CountW'(i_q) == len_m1);
  end

  // Four field stores.
  for (genvar g = 0; g < rss_pkg::NumFields; g++) begin : g_store
    rss_ram #(
      .Width (rss_pkg::WordW),
      .Depth (rss_pkg::Capacity)
    ) u_store (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .waddr_i (ram_waddr),
      .wdata_i (ram_wdata[g]),
      .re_i    (ram_re[g]),
      .raddr_i (ram_raddr),
      .rdata_o (ram_rdata[g])
    );
  end

  // Partner index generator.
  rss_draw u_draw (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (draw_ctrl),
    .run_len_i (run_len),
    .j_o       (j_draw)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rss_pkg::ST_LOAD;
      load_q  <= '0;
      i_q     <= '0;
      f_q     <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      i_q     <= i_d;
      f_q     <= f_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    j_q   <= j_d;
    a_q   <= a_d;
    out_q <= out_d;
  end

  // Sequencer: load, swap each field of each index, then emit.
  always_comb begin
    state_d    = state_q;
    load_d     = load_q;
    i_d        = i_q;
    f_d        = f_q;
    j_d        = j_q;
    a_d        = a_q;
    out_d      = out_q;
    draw_ctrl  = '0;
    ram_we     = '0;
    ram_re     = '0;
    ram_waddr  = i_q;
    ram_raddr  = i_q;
    ram_wdata  = ram_rdata;
    in_ready_o = 1'b0;

    case (state_q)
      rss_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        ram_waddr  = load_at[rss_pkg::AddrW-1:0];
        ram_wdata[rss_pkg::FieldPos]  = in_data_i.position;
        ram_wdata[rss_pkg::FieldMomX] = in_data_i.mom_x;
        ram_wdata[rss_pkg::FieldMomY] = in_data_i.mom_y;
        ram_wdata[rss_pkg::FieldMomZ] = in_data_i.mom_z;
        if (in_valid_i) begin
          ram_we = '1;
          if (load_at == len_m1) begin
            load_d  = '0;
            i_d     = '0;
            f_d     = rss_pkg::FieldPos;
            state_d = rss_pkg::ST_MUL;
          end else begin
            load_d = load_at + 1'b1;
          end
        end
      end
      rss_pkg::ST_MUL: begin
        draw_ctrl.mul_en = 1'b1;
        ram_re[f_q]      = 1'b1;
        state_d          = rss_pkg::ST_FOLD;
      end
      rss_pkg::ST_FOLD: begin
        draw_ctrl.fold_en = 1'b1;
        a_d               = ram_rdata[f_q];
        state_d           = rss_pkg::ST_SCALE;
      end
      rss_pkg::ST_SCALE: begin
        draw_ctrl.scale_en = 1'b1;
        state_d            = rss_pkg::ST_DIV;
      end
      rss_pkg::ST_DIV: begin
        ram_re[f_q] = 1'b1;
        ram_raddr   = j_draw;
        j_d         = j_draw;
        state_d     = rss_pkg::ST_WR_I;
      end
      rss_pkg::ST_WR_I: begin
        // Element j moves to i.
        ram_we[f_q] = 1'b1;
        state_d     = rss_pkg::ST_WR_J;
      end
      rss_pkg::ST_WR_J: begin
        // Old element i moves to j.
        ram_we[f_q] = 1'b1;
        ram_waddr   = j_q;
        ram_wdata   = {rss_pkg::NumFields{a_q}};
        f_d         = f_q + 1'b1;
        state_d     = rss_pkg::ST_MUL;
        if (f_q == rss_pkg::FieldMomZ) begin
          if (i_last) begin
            i_d     = '0;
            state_d = rss_pkg::ST_E_RD;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      rss_pkg::ST_E_RD: begin
        ram_re  = '1;
        state_d = rss_pkg::ST_E_LD;
      end
      rss_pkg::ST_E_LD: begin
        out_d.out_position = ram_rdata[rss_pkg::FieldPos];
        out_d.out_mom_x    = ram_rdata[rss_pkg::FieldMomX];
        out_d.out_mom_y    = ram_rdata[rss_pkg::FieldMomY];
        out_d.out_mom_z    = ram_rdata[rss_pkg::FieldMomZ];
        out_d.last         = i_last;
        state_d            = rss_pkg::ST_E_OUT;
      end
      rss_pkg::ST_E_OUT: begin
        if (out_ready_i) begin
          if (i_last) begin
            i_d     = '0;
            state_d = rss_pkg::ST_LOAD;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = rss_pkg::ST_E_RD;
          end
        end
      end
      default: begin
        state_d = rss_pkg::ST_LOAD;
      end
    endcase
  end

  assign out_valid_o = (state_q == rss_pkg::ST_E_OUT);
  assign out_data_o  = out_q;

  // Loading and emitting never overlap.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a word is pending");

  // During a shuffle at most one store is written per cycle.
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rss_pkg::ST_LOAD) |-> $onehot0(ram_we))
    else $error("more than one store written during shuffle");

  // The swap partner lies inside the run.
  a_partner_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rss_pkg::ST_WR_J) |-> (rss_pkg::CountW'(j_q) < run_len))
    else $error("swap partner beyond run length");

  // The last flag marks exactly the final index of the run.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == i_last))
    else $error("last flag does not match the final index");

endmodule

`default_nettype wire
